// File: design/tlfla_pkg.sv
// ----------------------------------------------------------------------------
// tlfla_pkg
// Types and constants shared by the two-level free-list allocator modules.
// ----------------------------------------------------------------------------
package tlfla_pkg;

	localparam int UNIT_W = 10;
	localparam int BLK_W  = 8;
	localparam int CNT_W  = 11;
	localparam int BCNT_W = 9;
	localparam int PAGE_W = 5;

	localparam logic [CNT_W-1:0]  CNT_MAX        = '1;
	localparam logic [BCNT_W-1:0] BCNT_MAX       = '1;
	localparam logic [UNIT_W:0]   UNIT_EMPTY     = 11'd1024;
	localparam logic [BLK_W:0]    BLK_EMPTY      = 9'd256;
	localparam logic [PAGE_W-1:0] PAGE_LIMIT_RST = 5'd16;

	localparam logic OP_ALLOC    = 1'b0;
	localparam logic OP_FREE     = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic clear_result;
		logic do_free;
		logic set_full;
		logic pfill;
		logic blk_pop;
		logic ufill;
		logic unit_pop;
		logic load_out;
	} tlfla_cmd_t;

	typedef struct packed {
		logic fuc_zero;
		logic fbc_zero;
		logic page_ok;
		logic pfill_last;
		logic ufill_last;
		logic out_free;
	} tlfla_stat_t;

endpackage

// File: design/two_level_free_list_allocator.sv
// ----------------------------------------------------------------------------
// two_level_free_list_allocator
// Small-unit allocator fed by block and page free lists, with a stream port.
// ----------------------------------------------------------------------------
// Each input word is either an allocate or a free, and each gives exactly one
// result word. A free writes the freed unit in as the new head of the unit
// free list; an allocate pops the head. An allocate that finds the unit list
// empty first pops a block and threads its units one link write per cycle;
// if the block list is also empty a page is added before that, and its
// blocks are threaded one per cycle. Each pop waits for the registered read
// of the link memory that holds the next link, and the threading pace
// follows from the single write port of each link memory.
// A finished word waits in the output register, so the next word is taken
// while the previous result is still unread, as long as no second result is
// ready before the first one leaves. The link memories need no clearing
// after reset. The page limit may be written only while the block is idle.
module two_level_free_list_allocator #(
	parameter int MAX_PAGES            = 16,
	parameter int BLOCKS_PER_PAGE_LOG2 = 4,
	parameter int UNITS_PER_BLOCK      = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // free_id [9:0], zero padding [15:10]
	input  logic [0:0]  s_axis_tuser,  // operation [0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // granted_id [9:0], free_units [20:10], used_units [31:21]
	output logic [0:0]  m_axis_tuser,  // status [0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);
	import tlfla_pkg::*;

	tlfla_cmd_t  cmd;
	tlfla_stat_t stat;

	assign cfg_ready = 1'b1;

	tlfla_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_op   (s_axis_tuser[0]),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	tlfla_datapath #(
		.MAX_PAGES           (MAX_PAGES),
		.BLOCKS_PER_PAGE_LOG2(BLOCKS_PER_PAGE_LOG2),
		.UNITS_PER_BLOCK     (UNITS_PER_BLOCK)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_free_id(s_axis_tdata[9:0]),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_status(m_axis_tuser[0])
	);

`ifndef NO_ASSERTIONS
	// A full result never carries a granted id.
	a_full_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0] == STATUS_FULL) |-> (m_axis_tdata[9:0] == '0))
		else $error("full result carries a nonzero granted id");

	// Only one list operation acts on the heads and counters in a cycle.
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.do_free, cmd.pfill, cmd.blk_pop, cmd.ufill, cmd.unit_pop}))
		else $error("conflicting list operations in one cycle");

	// After a word is taken the block is busy until its result is produced.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken again before the previous word finished");
`endif

endmodule

// File: design/tlfla_ram.sv
// ----------------------------------------------------------------------------
// tlfla_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tlfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/tlfla_ctrl.sv
// ----------------------------------------------------------------------------
// tlfla_ctrl
// Sequencer for allocate and free: pops, page and block carving, result.
// ----------------------------------------------------------------------------
module tlfla_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_op,
	output logic                   in_ready,
	input  tlfla_pkg::tlfla_stat_t stat,
	output tlfla_pkg::tlfla_cmd_t  cmd
);
	import tlfla_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_PFILL  = 8'b0000_0010,
		S_BREAD  = 8'b0000_0100,
		S_BWAIT  = 8'b0000_1000,
		S_UFILL  = 8'b0001_0000,
		S_UREAD  = 8'b0010_0000,
		S_UWAIT  = 8'b0100_0000,
		S_RESULT = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.clear_result = 1'b1;
					if (in_op == OP_FREE) begin
						cmd.do_free = 1'b1;
						state_d     = S_RESULT;
					end else if (!stat.fuc_zero) begin
						state_d = S_UWAIT;
					end else if (!stat.fbc_zero) begin
						state_d = S_BWAIT;
					end else if (stat.page_ok) begin
						state_d = S_PFILL;
					end else begin
						cmd.set_full = 1'b1;
						state_d      = S_RESULT;
					end
				end
			end
			S_PFILL: begin
				cmd.pfill = 1'b1;
				if (stat.pfill_last) begin
					state_d = S_BREAD;
				end
			end
			S_BREAD: begin
				state_d = S_BWAIT;
			end
			S_BWAIT: begin
				cmd.blk_pop = 1'b1;
				state_d     = S_UFILL;
			end
			S_UFILL: begin
				cmd.ufill = 1'b1;
				if (stat.ufill_last) begin
					state_d = S_UREAD;
				end
			end
			S_UREAD: begin
				state_d = S_UWAIT;
			end
			S_UWAIT: begin
				cmd.unit_pop = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/tlfla_datapath.sv
// ----------------------------------------------------------------------------
// tlfla_datapath
// List heads, counters, link memories, page limit and the result register.
// ----------------------------------------------------------------------------
module tlfla_datapath #(
	parameter int MAX_PAGES            = 16,
	parameter int BLOCKS_PER_PAGE_LOG2 = 4,
	parameter int UNITS_PER_BLOCK      = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tlfla_pkg::tlfla_cmd_t  cmd,
	output tlfla_pkg::tlfla_stat_t stat,
	input  logic [9:0]             in_free_id,
	input  logic                   cfg_valid,
	input  logic [4:0]             cfg_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [31:0]            out_data,
	output logic                   out_status
);
	import tlfla_pkg::*;

	localparam int UCW    = $clog2(UNITS_PER_BLOCK);
	localparam int PCW    = BLOCKS_PER_PAGE_LOG2;
	localparam int BLOCKS = 1 << BLOCKS_PER_PAGE_LOG2;
	localparam logic [8:0]     MAX_PAGES_C = 9'(MAX_PAGES);
	localparam logic [9:0]     BLOCKS_C    = 10'(BLOCKS);
	localparam logic [11:0]    UPB_C       = 12'(UNITS_PER_BLOCK);
	localparam logic [14:0]    UPB_MUL     = 15'(UNITS_PER_BLOCK);
	localparam logic [UCW-1:0] UCNT_LAST   = UCW'(UNITS_PER_BLOCK - 1);

	logic [UNIT_W:0]   unit_head_q;
	logic [BLK_W:0]    block_head_q;
	logic [PAGE_W-1:0] page_cursor_q;
	logic [PAGE_W-1:0] page_limit_q;
	logic [CNT_W-1:0]  fuc_q;
	logic [CNT_W-1:0]  used_q;
	logic [BCNT_W-1:0] fbc_q;
	logic [PCW-1:0]    pcnt_q;
	logic [UCW-1:0]    ucnt_q;
	logic [UNIT_W-1:0] ubase_q;
	logic              status_q;
	logic [UNIT_W-1:0] granted_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;
	logic              out_status_q;

	logic [5:0]        nxt;
	logic [8:0]        limit;
	logic [13:0]       pbase_wide;
	logic [BLK_W-1:0]  pbase;
	logic [11:0]       fuc_sum;
	logic [CNT_W-1:0]  fuc_grow;
	logic [CNT_W-1:0]  fuc_inc;
	logic [CNT_W-1:0]  used_inc;
	logic [CNT_W-1:0]  used_dec;
	logic [9:0]        fbc_sum;
	logic [BCNT_W-1:0] fbc_grow;
	logic [UNIT_W-1:0] unit_tail;
	logic [BLK_W-1:0]  blk_tail;
	logic [14:0]       blk_units;
	logic [UNIT_W-1:0] uaddr;

	logic              u_we;
	logic [UNIT_W-1:0] u_waddr;
	logic [UNIT_W-1:0] u_wdata;
	logic [UNIT_W-1:0] u_rdata;
	logic [BLK_W-1:0]  b_waddr;
	logic [BLK_W-1:0]  b_wdata;
	logic [BLK_W-1:0]  b_rdata;

	assign nxt        = {1'b0, page_cursor_q} + 6'd1;
	assign limit      = (MAX_PAGES_C < {4'd0, page_limit_q}) ? MAX_PAGES_C : {4'd0, page_limit_q};
	assign pbase_wide = {8'd0, nxt} << BLOCKS_PER_PAGE_LOG2;
	assign pbase      = pbase_wide[BLK_W-1:0];

	assign fuc_sum  = {1'b0, fuc_q} + UPB_C;
	assign fuc_grow = (fuc_sum > {1'b0, CNT_MAX}) ? CNT_MAX : fuc_sum[CNT_W-1:0];
	assign fuc_inc  = (fuc_q == CNT_MAX) ? fuc_q : fuc_q + 11'd1;
	assign used_inc = (used_q == CNT_MAX) ? used_q : used_q + 11'd1;
	assign used_dec = (used_q == '0) ? used_q : used_q - 11'd1;
	assign fbc_sum  = {1'b0, fbc_q} + BLOCKS_C;
	assign fbc_grow = (fbc_sum > {1'b0, BCNT_MAX}) ? BCNT_MAX : fbc_sum[BCNT_W-1:0];

	assign unit_tail = (fuc_q == '0) ? '0 : unit_head_q[UNIT_W-1:0];
	assign blk_tail  = (fbc_q == '0) ? '0 : block_head_q[BLK_W-1:0];
	assign blk_units = 15'(block_head_q[BLK_W-1:0]) * UPB_MUL;
	assign uaddr     = ubase_q + 10'(ucnt_q);

	assign stat.fuc_zero   = (fuc_q == '0);
	assign stat.fbc_zero   = (fbc_q == '0);
	assign stat.page_ok    = ({3'd0, nxt} < limit);
	assign stat.pfill_last = &pcnt_q;
	assign stat.ufill_last = (ucnt_q == UCNT_LAST);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign u_we    = cmd.do_free | cmd.ufill;
	assign u_waddr = cmd.do_free ? in_free_id : uaddr;
	assign u_wdata = (cmd.do_free || stat.ufill_last) ? unit_tail : uaddr + 10'd1;
	assign b_waddr = pbase + 8'(pcnt_q);
	assign b_wdata = stat.pfill_last ? blk_tail : b_waddr + 8'd1;

	tlfla_ram #(
		.WIDTH(UNIT_W),
		.DEPTH(1024)
	) u_unit_ram (
		.clk  (clk),
		.we   (u_we),
		.waddr(u_waddr),
		.wdata(u_wdata),
		.raddr(unit_head_q[UNIT_W-1:0]),
		.rdata(u_rdata)
	);

	tlfla_ram #(
		.WIDTH(BLK_W),
		.DEPTH(256)
	) u_block_ram (
		.clk  (clk),
		.we   (cmd.pfill),
		.waddr(b_waddr),
		.wdata(b_wdata),
		.raddr(block_head_q[BLK_W-1:0]),
		.rdata(b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_head_q   <= UNIT_EMPTY;
			block_head_q  <= BLK_EMPTY;
			page_cursor_q <= '0;
			page_limit_q  <= PAGE_LIMIT_RST;
			fuc_q         <= '0;
			used_q        <= '0;
			fbc_q         <= '0;
			pcnt_q        <= '0;
			ucnt_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				page_limit_q <= cfg_data;
			end
			if (cmd.do_free) begin
				unit_head_q <= {1'b0, in_free_id};
				fuc_q       <= fuc_inc;
				used_q      <= used_dec;
			end
			if (cmd.pfill) begin
				pcnt_q <= pcnt_q + 1'b1;
				if (stat.pfill_last) begin
					block_head_q  <= {1'b0, pbase};
					fbc_q         <= fbc_grow;
					page_cursor_q <= nxt[PAGE_W-1:0];
				end
			end
			if (cmd.blk_pop) begin
				fbc_q        <= fbc_q - 9'd1;
				block_head_q <= (fbc_q == 9'd1) ? BLK_EMPTY : {1'b0, b_rdata};
			end
			if (cmd.ufill) begin
				if (stat.ufill_last) begin
					ucnt_q      <= '0;
					unit_head_q <= {1'b0, ubase_q};
					fuc_q       <= fuc_grow;
				end else begin
					ucnt_q <= ucnt_q + 1'b1;
				end
			end
			if (cmd.unit_pop) begin
				fuc_q       <= fuc_q - 11'd1;
				unit_head_q <= (fuc_q == 11'd1) ? UNIT_EMPTY : {1'b0, u_rdata};
				used_q      <= used_inc;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.blk_pop) begin
			ubase_q <= blk_units[UNIT_W-1:0];
		end
		if (cmd.clear_result) begin
			status_q  <= cmd.set_full ? STATUS_FULL : STATUS_OK;
			granted_q <= '0;
		end
		if (cmd.unit_pop) begin
			granted_q <= unit_head_q[UNIT_W-1:0];
		end
		if (cmd.load_out) begin
			out_data_q   <= {used_q, fuc_q, granted_q};
			out_status_q <= status_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;

endmodule

// File: dv/two_level_free_list_allocator_test.sv
// ----------------------------------------------------------------------------
// two_level_free_list_allocator_test
// Self-checking stream testbench for the two-level free-list allocator.
// ----------------------------------------------------------------------------
// The run starts with a short table of directed words. It covers a page limit
// of one, frees of the lowest and highest ids, double frees and full replies.
// Random phases follow, each under its own page limit. Every accepted word is
// run through a cycle-free model of the unit, block and page lists, and each
// result word is compared with the oldest predicted one. Both stream sides
// pause at random between words.
// ----------------------------------------------------------------------------
module two_level_free_list_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tlfla_pkg::*;

	localparam int MAX_PAGES       = 16;
	localparam int BLOCKS_LOG2     = 4;
	localparam int UNITS_PER_BLOCK = 4;
	localparam int BLOCKS_PER_PAGE = 1 << BLOCKS_LOG2;
	localparam int UNIT_MASK       = (1 << UNIT_W) - 1;
	localparam int BLK_MASK        = (1 << BLK_W) - 1;
	localparam int MAX_GAP         = 17;
	localparam int STALL_LIMIT     = 2000;
	localparam int PHASES          = 8;
	localparam int PHASE_WORDS     = 60;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		logic              status;
		logic [UNIT_W-1:0] granted;
		logic [CNT_W-1:0]  free_units;
		logic [CNT_W-1:0]  used_units;
	} alloc_result_t;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e         kind;
		logic              op;
		logic [UNIT_W-1:0] id;
		logic [PAGE_W-1:0] limit;
		logic              typed;
		alloc_result_t     want;
	} plan_row_t;

	localparam plan_row_t PLAN [23] = '{
		'{ROW_CFG,  OP_ALLOC, 10'd0,    5'd1,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b1, '{STATUS_FULL, 10'd0, 11'd0, 11'd0}},
		'{ROW_WORD, OP_FREE,  10'd1023, 5'd0,  1'b1, '{STATUS_OK, 10'd0, 11'd1, 11'd0}},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b1, '{STATUS_OK, 10'd1023, 11'd0, 11'd1}},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b1, '{STATUS_FULL, 10'd0, 11'd0, 11'd1}},
		'{ROW_WORD, OP_FREE,  10'd0,    5'd0,  1'b1, '{STATUS_OK, 10'd0, 11'd1, 11'd0}},
		'{ROW_WORD, OP_FREE,  10'd0,    5'd0,  1'b1, '{STATUS_OK, 10'd0, 11'd2, 11'd0}},
		'{ROW_WORD, OP_ALLOC, 10'd1023, 5'd0,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b1, '{STATUS_FULL, 10'd0, 11'd0, 11'd2}},
		'{ROW_CFG,  OP_ALLOC, 10'd0,    5'd2,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b0, '0},
		'{ROW_WORD, OP_FREE,  10'd65,   5'd0,  1'b0, '0},
		'{ROW_WORD, OP_FREE,  10'd700,  5'd0,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd682,  5'd0,  1'b0, '0},
		'{ROW_CFG,  OP_ALLOC, 10'd0,    5'd15, 1'b0, '0},
		'{ROW_WORD, OP_FREE,  10'd341,  5'd0,  1'b0, '0},
		'{ROW_WORD, OP_ALLOC, 10'd0,    5'd0,  1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;

	logic [UNIT_W-1:0] unit_link [1 << UNIT_W];
	logic [BLK_W-1:0]  block_link [1 << BLK_W];
	logic [UNIT_W:0]   unit_top;
	logic [BLK_W:0]    block_top;
	logic [PAGE_W-1:0] last_page;
	logic [CNT_W-1:0]  units_free;
	logic [CNT_W-1:0]  units_used;
	logic [BCNT_W-1:0] blocks_free;
	logic [PAGE_W-1:0] page_limit_q;

	logic [UNIT_W-1:0] held_ids [$];
	alloc_result_t     pending_results [$];

	bit calm;
	int bad_words;
	int n_allocs;
	int n_frees;
	int n_full;
	int n_cfg;

	two_level_free_list_allocator #(
		.MAX_PAGES(MAX_PAGES),
		.BLOCKS_PER_PAGE_LOG2(BLOCKS_LOG2),
		.UNITS_PER_BLOCK(UNITS_PER_BLOCK)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int clip(int value, int top);
		return (value > top) ? top : value;
	endfunction

	function automatic int draw_gap();
		if (calm || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic bit open_page();
		int lim;
		int nxt;
		int base;
		int i;
		lim = (int'(page_limit_q) > MAX_PAGES) ? MAX_PAGES : int'(page_limit_q);
		nxt = int'(last_page) + 1;
		if (nxt >= lim)
			return 1'b0;
		last_page = PAGE_W'(nxt);
		base = nxt << BLOCKS_LOG2;
		for (i = 0; i + 1 < BLOCKS_PER_PAGE; i++)
			block_link[(base + i) & BLK_MASK] = BLK_W'((base + i + 1) & BLK_MASK);
		block_link[(base + BLOCKS_PER_PAGE - 1) & BLK_MASK] =
			(blocks_free == 0) ? '0 : block_top[BLK_W-1:0];
		block_top = (BLK_W+1)'(base & BLK_MASK);
		blocks_free = BCNT_W'(clip(int'(blocks_free) + BLOCKS_PER_PAGE, int'(BCNT_MAX)));
		return 1'b1;
	endfunction

	function automatic bit carve_block();
		int blk;
		int base;
		int i;
		if (blocks_free == 0) begin
			if (!open_page())
				return 1'b0;
		end
		blk = int'(block_top[BLK_W-1:0]);
		blocks_free = blocks_free - 1'b1;
		block_top = (blocks_free == 0) ? BLK_EMPTY : {1'b0, block_link[blk]};
		base = blk * UNITS_PER_BLOCK;
		for (i = 0; i + 1 < UNITS_PER_BLOCK; i++)
			unit_link[(base + i) & UNIT_MASK] = UNIT_W'((base + i + 1) & UNIT_MASK);
		unit_link[(base + UNITS_PER_BLOCK - 1) & UNIT_MASK] =
			(units_free == 0) ? '0 : unit_top[UNIT_W-1:0];
		unit_top = (UNIT_W+1)'(base & UNIT_MASK);
		units_free = CNT_W'(clip(int'(units_free) + UNITS_PER_BLOCK, int'(CNT_MAX)));
		return 1'b1;
	endfunction

	function automatic alloc_result_t predict_word(logic op, logic [UNIT_W-1:0] id);
		alloc_result_t r;
		bit ok;
		int found [$];
		r = '0;
		if (op == OP_FREE) begin
			n_frees++;
			unit_link[id] = (units_free == 0) ? '0 : unit_top[UNIT_W-1:0];
			unit_top = {1'b0, id};
			units_free = CNT_W'(clip(int'(units_free) + 1, int'(CNT_MAX)));
			if (units_used > 0)
				units_used = units_used - 1'b1;
			found = held_ids.find_first_index(x) with (x == id);
			if (found.size() != 0)
				held_ids.delete(found[0]);
		end else begin
			n_allocs++;
			ok = 1'b1;
			if (units_free == 0)
				ok = carve_block();
			if (!ok) begin
				n_full++;
				r.status = STATUS_FULL;
			end else begin
				r.status = STATUS_OK;
				r.granted = unit_top[UNIT_W-1:0];
				units_free = units_free - 1'b1;
				unit_top = (units_free == 0) ? UNIT_EMPTY : {1'b0, unit_link[r.granted]};
				units_used = CNT_W'(clip(int'(units_used) + 1, int'(CNT_MAX)));
				held_ids.push_back(r.granted);
			end
		end
		r.free_units = units_free;
		r.used_units = units_used;
		return r;
	endfunction

	task automatic send_word(input logic op, input logic [UNIT_W-1:0] id, input bit typed,
			input alloc_result_t typed_result);
		int gap;
		alloc_result_t model;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= 16'(id);
		do @(posedge clk); while (!s_axis_tready);
		model = predict_word(op, id);
		pending_results.push_back(typed ? typed_result : model);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_page_limit(input logic [PAGE_W-1:0] limit);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data  <= limit;
		do @(posedge clk); while (!cfg_ready);
		page_limit_q = limit;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int stall;
		alloc_result_t seen;
		alloc_result_t want;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			seen.status     = m_axis_tuser[0];
			seen.granted    = m_axis_tdata[UNIT_W-1:0];
			seen.free_units = m_axis_tdata[UNIT_W +: CNT_W];
			seen.used_units = m_axis_tdata[UNIT_W+CNT_W +: CNT_W];
			if (pending_results.size() == 0) begin
				bad_words++;
				if (bad_words <= REPORT_LIMIT)
					$display("%0t: result word with none expected: status %0d id %0d free %0d used %0d",
						$realtime, seen.status, seen.granted, seen.free_units, seen.used_units);
			end else begin
				want = pending_results.pop_front();
				if (seen !== want) begin
					bad_words++;
					if (bad_words <= REPORT_LIMIT)
						$display("%0t: expected status %0d id %0d free %0d used %0d, got status %0d id %0d free %0d used %0d",
							$realtime, want.status, want.granted, want.free_units,
							want.used_units, seen.status, seen.granted, seen.free_units,
							seen.used_units);
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		int k;
		int phase;
		int n;
		int r;
		int alloc_pct;
		int next_limit;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		calm          = 1'b0;
		bad_words     = 0;
		n_allocs      = 0;
		n_frees       = 0;
		n_full        = 0;
		n_cfg         = 0;
		unit_top      = UNIT_EMPTY;
		block_top     = BLK_EMPTY;
		last_page     = '0;
		units_free    = '0;
		units_used    = '0;
		blocks_free   = '0;
		page_limit_q  = PAGE_LIMIT_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < $size(PLAN); k++) begin
			if (PLAN[k].kind == ROW_CFG)
				write_page_limit(PLAN[k].limit);
			else
				send_word(PLAN[k].op, PLAN[k].id, PLAN[k].typed, PLAN[k].want);
		end

		// Most phases allow at most one new page, so the lists run dry and full replies show up.
		for (phase = 0; phase < PHASES; phase++) begin
			next_limit = int'(last_page) + 1 + $urandom_range(0, 1);
			if ($urandom_range(0, 5) == 0)
				next_limit = 1;
			if (phase == PHASES - 1 || next_limit > MAX_PAGES)
				next_limit = MAX_PAGES;
			write_page_limit(PAGE_W'(next_limit));
			calm = (phase % 3 == 1);
			alloc_pct = (phase % 2 == 0) ? 80 : 45;
			for (n = 0; n < PHASE_WORDS; n++) begin
				if ($urandom_range(0, 99) == 0)
					wait_for_results();
				r = $urandom_range(0, 99);
				if (r >= 92)
					send_word(OP_FREE, UNIT_W'($urandom), 1'b0, '0);
				else if (r < alloc_pct || held_ids.size() == 0)
					send_word(OP_ALLOC, UNIT_W'($urandom), 1'b0, '0);
				else
					send_word(OP_FREE, held_ids[$urandom_range(0, held_ids.size() - 1)],
						1'b0, '0);
			end
		end

		calm = 1'b0;
		wait_for_results();
		repeat (20) @(posedge clk);
		$display("run: %0d words (%0d allocate, %0d free), %0d full replies, %0d pages opened",
			n_allocs + n_frees, n_allocs, n_frees, n_full, last_page);
		$display("run: page limit written %0d times, %0d bad result words", n_cfg, bad_words);
		if (bad_words == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
